FILE: rtl/atok_pkg.sv
package atok_pkg;

	// scanner modes
	typedef enum logic [2:0] {
		MODE_IDLE,
		MODE_ZERO,
		MODE_INT,
		MODE_HEX,
		MODE_BIN,
		MODE_WORD
	} scan_mode_t;

	// token kinds
	localparam logic [4:0] KIND_EOF        = 5'd0;
	localparam logic [4:0] KIND_ILLEGAL    = 5'd1;
	localparam logic [4:0] KIND_INT        = 5'd2;
	localparam logic [4:0] KIND_HEX        = 5'd3;
	localparam logic [4:0] KIND_BIN        = 5'd4;
	localparam logic [4:0] KIND_FIRST_WORD = 5'd5;

	// character codes
	localparam logic [7:0] CH_NUL        = 8'h00;
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NL         = 8'h0a;
	localparam logic [7:0] CH_CR         = 8'h0d;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_ZERO       = 8'h30;
	localparam logic [7:0] CH_ONE        = 8'h31;
	localparam logic [7:0] CH_NINE       = 8'h39;
	localparam logic [7:0] CH_UPPER_A    = 8'h41;
	localparam logic [7:0] CH_UPPER_F    = 8'h46;
	localparam logic [7:0] CH_UPPER_Z    = 8'h5a;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
	localparam logic [7:0] CH_LOWER_A    = 8'h61;
	localparam logic [7:0] CH_LOWER_B    = 8'h62;
	localparam logic [7:0] CH_LOWER_F    = 8'h66;
	localparam logic [7:0] CH_LOWER_X    = 8'h78;
	localparam logic [7:0] CH_LOWER_Z    = 8'h7a;

	// mnemonic table, first letter in the low byte, zero padded
	localparam int NUM_KEYWORDS = 19;
	localparam int KW_TEXT_LEN  = 4;

	localparam logic [8*KW_TEXT_LEN-1:0] MNEMONIC_TEXT [NUM_KEYWORDS] = '{
		32'h00706f6e, // nop
		32'h0061646c, // lda
		32'h0062646c, // ldb
		32'h00617473, // sta
		32'h00627473, // stb
		32'h61746573, // seta
		32'h62746573, // setb
		32'h00746f6e, // not
		32'h00646e61, // and
		32'h0000726f, // or
		32'h00726f78, // xor
		32'h646e616e, // nand
		32'h00726f6e, // nor
		32'h00646461, // add
		32'h00627573, // sub
		32'h00706d6a, // jmp
		32'h7a706d6a, // jmpz
		32'h63706d6a, // jmpc
		32'h00746c68  // hlt
	};

	localparam logic [2:0] MNEMONIC_LEN [NUM_KEYWORDS] = '{
		3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd2,
		3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4, 3'd3
	};

	// output queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_BITS = 2;

	typedef struct packed {
		logic [4:0]  kind;
		logic [15:0] start;
		logic [15:0] length;
		logic        last;
	} token_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic is_hex_digit(input logic [7:0] c);
		return is_digit(c) || ((c >= CH_LOWER_A) && (c <= CH_LOWER_F))
			|| ((c >= CH_UPPER_A) && (c <= CH_UPPER_F));
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z))
			|| ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERSCORE);
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL) || (c == CH_CR);
	endfunction

endpackage

FILE: rtl/assembly_tokenizer.sv
// output: tokens closed by a taken item are queued and offered on m_* in queue order
// throughput: one character item per cycle while each item yields at most one token and
//   m_tready stays high; items that yield two tokens (closing token plus illegal or eof)
//   can stall input, set by the single-token output port draining a four-entry result queue
// reset: arst_n low clears the scanner to idle at offset zero and empties the result queue
module assembly_tokenizer import atok_pkg::*; #(
	parameter int POS_BITS    = 16,
	parameter int KEYWORD_MAX = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	// character items in
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] char_byte
	input  logic        s_tuser,  // [0] is_end
	// token items out
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] token_start, [31:16] token_length
	output logic [4:0]  m_tuser,  // [4:0] token_kind
	output logic        m_tlast   // is_last
);

	localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
	localparam int KW_IDX_BITS = $clog2(KEYWORD_MAX);

	// scanner state
	scan_mode_t          mode_q, mode_d;
	logic [POS_BITS-1:0] char_pos_q, char_pos_d;
	logic [POS_BITS-1:0] open_start_q, open_start_d;
	logic [POS_BITS-1:0] open_len_q, open_len_d;
	logic [7:0]          letters_q [KEYWORD_MAX];
	logic [7:0]          letters_d [KEYWORD_MAX];
	logic                too_long_q, too_long_d;

	// result queue
	token_t                 oq_q [OQ_DEPTH];
	logic [OQ_PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [OQ_PTR_BITS:0]   count_q;

	logic     take, pop;
	logic [7:0] c;
	logic     in_end;
	logic     push_a, push_b;
	token_t   tok_a, tok_b;
	token_t   push0, push1;
	logic [1:0] n_push;
	logic [4:0] open_kind;
	logic [4:0] word_kind;
	logic [8*KW_TEXT_LEN-1:0] word_text;

	function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
		return (v == POS_MAX) ? POS_MAX : v + 1'b1;
	endfunction

	function automatic logic [15:0] low16(input logic [POS_BITS-1:0] v);
		logic [31:0] w;
		w = 32'(v);
		return w[15:0];
	endfunction

	// room for the two tokens one item can produce
	assign s_tready = (count_q <= (OQ_PTR_BITS+1)'(OQ_DEPTH - 2));
	assign take     = s_tvalid && s_tready;
	assign m_tvalid = (count_q != '0);
	assign pop      = m_tvalid && m_tready;

	assign c      = s_tdata;
	assign in_end = s_tuser || (c == CH_NUL);

	// exact keyword lookup over the first letters of the open word
	assign word_text = {letters_q[3], letters_q[2], letters_q[1], letters_q[0]};

	always_comb begin
		word_kind = KIND_ILLEGAL;
		if (!too_long_q && (open_len_q <= POS_BITS'(KEYWORD_MAX))) begin
			for (int k = 0; k < NUM_KEYWORDS; k++) begin
				if ((open_len_q == POS_BITS'(MNEMONIC_LEN[k])) && (word_text == MNEMONIC_TEXT[k]))
					word_kind = KIND_FIRST_WORD + 5'(k);
			end
		end
	end

	always_comb begin
		unique case (mode_q)
			MODE_ZERO, MODE_INT: open_kind = KIND_INT;
			MODE_HEX:            open_kind = KIND_HEX;
			MODE_BIN:            open_kind = KIND_BIN;
			default:             open_kind = word_kind;
		endcase
	end

	// one character step: next state and up to two tokens
	always_comb begin
		logic grown;
		mode_d       = mode_q;
		char_pos_d   = char_pos_q;
		open_start_d = open_start_q;
		open_len_d   = open_len_q;
		letters_d    = letters_q;
		too_long_d   = too_long_q;
		grown        = 1'b0;
		push_a       = 1'b0;
		push_b       = 1'b0;
		// token closed by this item
		tok_a.kind   = open_kind;
		tok_a.start  = low16(open_start_q);
		tok_a.length = low16(open_len_q);
		tok_a.last   = 1'b0;
		// eof or illegal single character
		tok_b.kind   = KIND_ILLEGAL;
		tok_b.start  = low16(char_pos_q);
		tok_b.length = 16'd1;
		tok_b.last   = 1'b1;

		if (in_end) begin
			push_a       = (mode_q != MODE_IDLE);
			push_b       = 1'b1;
			tok_b.kind   = KIND_EOF;
			tok_b.length = 16'd0;
			mode_d       = MODE_IDLE;
			char_pos_d   = '0;
			open_start_d = '0;
			open_len_d   = '0;
		end else begin
			char_pos_d = sat_inc(char_pos_q);
			unique case (mode_q)
				MODE_ZERO: begin
					if (c == CH_LOWER_X) begin
						mode_d = MODE_HEX;
						grown  = 1'b1;
					end else if (c == CH_LOWER_B) begin
						mode_d = MODE_BIN;
						grown  = 1'b1;
					end else if (is_digit(c)) begin
						mode_d = MODE_INT;
						grown  = 1'b1;
					end
				end
				MODE_INT: grown = is_digit(c);
				MODE_HEX: grown = is_hex_digit(c);
				MODE_BIN: grown = (c == CH_ZERO) || (c == CH_ONE);
				MODE_WORD: begin
					if (is_word_char(c)) begin
						grown = 1'b1;
						if (open_len_q < POS_BITS'(KEYWORD_MAX))
							letters_d[open_len_q[KW_IDX_BITS-1:0]] = c;
						else
							too_long_d = 1'b1;
					end
				end
				default: grown = 1'b0;
			endcase

			if (grown) begin
				open_len_d = sat_inc(open_len_q);
			end else begin
				push_a = (mode_q != MODE_IDLE);
				mode_d = MODE_IDLE;
				if (is_space(c)) begin
					// separator, nothing opens
				end else if (is_digit(c) || is_word_char(c)) begin
					if (c == CH_ZERO)
						mode_d = MODE_ZERO;
					else if (is_digit(c))
						mode_d = MODE_INT;
					else
						mode_d = MODE_WORD;
					open_start_d = char_pos_q;
					open_len_d   = POS_BITS'(1);
					too_long_d   = 1'b0;
					for (int i = 0; i < KEYWORD_MAX; i++)
						letters_d[i] = '0;
					if (!is_digit(c))
						letters_d[0] = c;
				end else begin
					push_b = 1'b1;
				end
			end
		end

		// the final token of this item carries last
		if (push_a && !push_b)
			tok_a.last = 1'b1;
	end

	// pack the tokens of this item into consecutive queue slots
	always_comb begin
		push0 = push_a ? tok_a : tok_b;
		push1 = tok_b;
		n_push = {1'b0, push_a} + {1'b0, push_b};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_IDLE;
			char_pos_q   <= '0;
			open_start_q <= '0;
			open_len_q   <= '0;
			too_long_q   <= 1'b0;
			for (int i = 0; i < KEYWORD_MAX; i++)
				letters_q[i] <= '0;
		end else if (take) begin
			mode_q       <= mode_d;
			char_pos_q   <= char_pos_d;
			open_start_q <= open_start_d;
			open_len_q   <= open_len_d;
			too_long_q   <= too_long_d;
			letters_q    <= letters_d;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (take)
				wr_ptr_q <= wr_ptr_q + OQ_PTR_BITS'(n_push);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (take ? (OQ_PTR_BITS+1)'(n_push) : '0)
				- (OQ_PTR_BITS+1)'(pop);
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (take && (n_push != 2'd0))
			oq_q[wr_ptr_q] <= push0;
		if (take && (n_push == 2'd2))
			oq_q[wr_ptr_q + 1'b1] <= push1;
	end

	// head of queue drives the output
	assign m_tdata = {oq_q[rd_ptr_q].length, oq_q[rd_ptr_q].start};
	assign m_tuser = oq_q[rd_ptr_q].kind;
	assign m_tlast = oq_q[rd_ptr_q].last;

endmodule
